### sv/sacd_pkg.sv
// ----------------------------------------------------------------------------
// sacd_pkg
// Shared constants and types for the servo ASCII command deframer.
// ----------------------------------------------------------------------------
package sacd_pkg;

  localparam int FRAME_MAX_DEFAULT = 32;
  localparam int BODY_MAX = 11;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] ID_BROADCAST = 8'd255;
  localparam logic [9:0] ID_SET_MAX   = 10'd254;

  localparam logic [2:0] REG_OWN_ID     = 3'd0;
  localparam logic [2:0] REG_PULSE_MIN  = 3'd1;
  localparam logic [2:0] REG_PULSE_MAX  = 3'd2;
  localparam logic [2:0] REG_TORQUE_MAX = 3'd3;
  localparam logic [2:0] REG_MODE_MASK  = 3'd4;
  localparam logic [2:0] REG_MODE_HIGH  = 3'd5;
  localparam logic [2:0] REG_BOOT_LOW   = 3'd6;
  localparam logic [2:0] REG_BOOT_HIGH  = 3'd7;

  typedef enum logic [4:0] {
    CMD_GOTO = 5'd0, CMD_GOTO_TURNS = 5'd1, CMD_VER = 5'd2, CMD_ID = 5'd3,
    CMD_ADDR_SET = 5'd4, CMD_ULK = 5'd5, CMD_ULM = 5'd6, CMD_ULR = 5'd7,
    CMD_MOD = 5'd8, CMD_MOD_SET = 5'd9, CMD_RAD = 5'd10, CMD_DPT = 5'd11,
    CMD_DCT = 5'd12, CMD_DST = 5'd13, CMD_BD = 5'd14, CMD_BD_SET = 5'd15,
    CMD_SCK = 5'd16, CMD_SCZ = 5'd17, CMD_CSD = 5'd18, CMD_CSM = 5'd19,
    CMD_CSM_SET = 5'd20, CMD_CLE0 = 5'd21, CMD_CLE = 5'd22, CMD_RTV = 5'd23,
    CMD_SP = 5'd24, CMD_SP_SET = 5'd25, CMD_AMI = 5'd26, CMD_AMX = 5'd27,
    CMD_SMI = 5'd28, CMD_SMX = 5'd29, CMD_RIV = 5'd30
  } cmd_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic [23:0] s3(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c);
    return {a, b, c};
  endfunction

endpackage

### sv/servo_ascii_command_deframer.sv
// ----------------------------------------------------------------------------
// servo_ascii_command_deframer
// Frames '#dddP...!' byte streams and decodes the body into one command.
//
//   channel  signals                                  role
//   in       in_valid / in_stall / rx_byte            serial byte request
//   out      out_valid / out_stall / command ...      decoded command request
//   cfg      cfg_we / cfg_index / cfg_data            register write
//
// A byte other than '!' never stalls the input. A '!' closing a frame of len
// bytes (7 to BODY_MAX + 6) starts a sequencer that reads the frame back one
// byte a cycle through one memory port and an ID digit accumulator; in_stall
// stays high through read-back and decode. Decode of a matching frame holds
// while an earlier result still waits on out_stall; the result register
// otherwise frees the input. Other frames end at once. rst clears framing
// and the result and resets the config registers; the store needs no clearing.
// ----------------------------------------------------------------------------
module servo_ascii_command_deframer #(
  parameter int FRAME_MAX = sacd_pkg::FRAME_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  command,
  output logic [13:0] target_pulse,
  output logic [13:0] argument,
  output logic [3:0]  turns,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(FRAME_MAX);
  localparam int CW = $clog2(FRAME_MAX + 1);
  localparam int BM = sacd_pkg::BODY_MAX;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001, ST_READ = 3'b010, ST_DECODE = 3'b100
  } state_t;

  state_t state;
  logic [7:0] frame_store [FRAME_MAX];
  logic [CW-1:0] frame_count;
  logic in_frame;
  logic [CW-1:0] rd_pos;
  logic [CW-1:0] rd_cnt;
  logic [7:0] rd_data;
  logic rd_ok;
  logic shape_ok;
  logic [9:0] id_acc;
  logic [7:0] body [BM];

  logic [7:0]  own_id;
  logic [13:0] pulse_min, pulse_max;
  logic [9:0]  torque_limit_max;
  logic [15:0] mode_supported_mask;
  logic [3:0]  mode_highest, boot_lowest, boot_highest;

  logic dec_ok;
  logic [4:0] dec_cmd;
  logic [13:0] dec_pulse, dec_arg;
  logic [3:0] dec_turns;
  logic hit;
  logic load_out;

  logic accept;
  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;

  assign hit = dec_ok && shape_ok && (id_acc == {2'b0, own_id} ||
               id_acc == {2'b0, sacd_pkg::ID_BROADCAST});
  assign load_out = (state == ST_DECODE) && (!out_valid || !out_stall) && hit;

  logic store_byte;
  assign store_byte = accept && rx_byte != sacd_pkg::CH_HASH && in_frame
                      && (frame_count < CW'(FRAME_MAX));

  always_ff @(posedge clk) begin
    if (accept && rx_byte == sacd_pkg::CH_HASH) frame_store[0] <= rx_byte;
    else if (store_byte) frame_store[frame_count[AW-1:0]] <= rx_byte;
    rd_data <= frame_store[rd_pos[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= 8'd0; pulse_min <= 14'd500; pulse_max <= 14'd2500;
      torque_limit_max <= 10'd100; mode_supported_mask <= 16'hFFFF;
      mode_highest <= 4'd15; boot_lowest <= 4'd0; boot_highest <= 4'd9;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sacd_pkg::REG_OWN_ID:     own_id <= cfg_data[7:0];
        sacd_pkg::REG_PULSE_MIN:  pulse_min <= cfg_data[13:0];
        sacd_pkg::REG_PULSE_MAX:  pulse_max <= cfg_data[13:0];
        sacd_pkg::REG_TORQUE_MAX: torque_limit_max <= cfg_data[9:0];
        sacd_pkg::REG_MODE_MASK:  mode_supported_mask <= cfg_data;
        sacd_pkg::REG_MODE_HIGH:  mode_highest <= cfg_data[3:0];
        sacd_pkg::REG_BOOT_LOW:   boot_lowest <= cfg_data[3:0];
        sacd_pkg::REG_BOOT_HIGH:  boot_highest <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // sequential read-back: byte at position rd_cnt arrives in rd_data
  logic [CW-1:0] blen;
  assign blen = frame_count - CW'(6);

  // position 0 holds the known '#', so reading starts at position 1;
  // rd_cnt is the position of rd_data, one read behind rd_pos
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; in_frame <= 1'b0; frame_count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (accept) begin
          if (rx_byte == sacd_pkg::CH_HASH) begin
            in_frame <= 1'b1; frame_count <= CW'(1);
          end else if (in_frame) begin
            if (frame_count >= CW'(FRAME_MAX)) in_frame <= 1'b0;
            else begin
              frame_count <= frame_count + CW'(1);
              if (rx_byte == sacd_pkg::CH_BANG) begin
                in_frame <= 1'b0;
                if (frame_count + CW'(1) >= CW'(7)
                    && frame_count + CW'(1) - CW'(6) <= CW'(BM)) begin
                  state <= ST_READ; rd_pos <= CW'(1); rd_cnt <= CW'(1);
                  rd_ok <= 1'b0; shape_ok <= 1'b1; id_acc <= '0;
                end
              end
            end
          end
        end
        ST_READ: begin
          rd_pos <= rd_pos + CW'(1);
          if (rd_ok) begin
            rd_cnt <= rd_cnt + CW'(1);
            if (rd_cnt >= CW'(1) && rd_cnt <= CW'(3)) begin
              if (!sacd_pkg::is_digit(rd_data)) shape_ok <= 1'b0;
              id_acc <= 10'(id_acc * 10'd10 + 10'(rd_data - sacd_pkg::CH_0));
            end
            if (rd_cnt == CW'(4) && rd_data != sacd_pkg::CH_P) shape_ok <= 1'b0;
            if (rd_cnt >= CW'(5) && rd_cnt - CW'(5) < CW'(BM))
              body[4'(rd_cnt - CW'(5))] <= rd_data;
            if (rd_cnt == frame_count - CW'(2)) state <= ST_DECODE;
          end
          rd_ok <= 1'b1;
        end
        ST_DECODE: if (!hit || !out_valid || !out_stall) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) begin
      out_valid <= 1'b1;
      command <= dec_cmd; target_pulse <= dec_pulse;
      argument <= dec_arg; turns <= dec_turns;
    end else if (!out_stall) out_valid <= 1'b0;
  end

  function automatic logic [13:0] dval(input logic [7:0] c);
    return 14'(c - sacd_pkg::CH_0);
  endfunction

  logic [13:0] p4, v4, v3, v1a, v1b, v2;
  logic dg [BM];
  logic [23:0] b3;
  logic [15:0] b2;
  always_comb begin
    for (int i = 0; i < BM; i++) dg[i] = sacd_pkg::is_digit(body[i]);
    p4 = 14'(dval(body[0]) * 14'd1000 + dval(body[1]) * 14'd100
             + dval(body[2]) * 14'd10 + dval(body[3]));
    v4 = 14'(dval(body[5]) * 14'd1000 + dval(body[6]) * 14'd100
             + dval(body[7]) * 14'd10 + dval(body[8]));
    v3 = 14'(dval(body[2]) * 14'd100 + dval(body[3]) * 14'd10 + dval(body[4]));
    v1a = dval(body[2]);
    v1b = dval(body[3]);
    v2 = 14'(dval(body[3]) * 14'd10 + dval(body[4]));
    b3 = {body[0], body[1], body[2]};
    b2 = {body[0], body[1]};
  end

  logic [13:0] v4n;
  assign v4n = 14'(dval(body[7]) * 14'd1000 + dval(body[8]) * 14'd100
                   + dval(body[9]) * 14'd10 + dval(body[10]));
  logic [13:0] mv;
  assign mv = (blen == CW'(5)) ? v2 : v1b;

  always_comb begin
    dec_ok = 1'b1; dec_cmd = sacd_pkg::CMD_GOTO;
    dec_pulse = '0; dec_arg = '0; dec_turns = '0;
    priority if (blen == CW'(11) && body[4] == sacd_pkg::CH_N
                 && body[6] == sacd_pkg::CH_T && dg[0] && dg[1] && dg[2] && dg[3]
                 && dg[5] && dg[7] && dg[8] && dg[9] && dg[10]) begin
      if (p4 < pulse_min || p4 > pulse_max) dec_ok = 1'b0;
      dec_cmd = sacd_pkg::CMD_GOTO_TURNS; dec_pulse = p4; dec_arg = v4n;
      dec_turns = 4'(dval(body[5]));
    end else if (blen == CW'(9) && body[4] == sacd_pkg::CH_T && dg[0] && dg[1]
                 && dg[2] && dg[3] && dg[5] && dg[6] && dg[7] && dg[8]) begin
      if (p4 < pulse_min || p4 > pulse_max) dec_ok = 1'b0;
      dec_pulse = p4; dec_arg = v4;
    end else if (blen == CW'(3) && b3 == sacd_pkg::s3("V", "E", "R"))
      dec_cmd = sacd_pkg::CMD_VER;
    else if (blen == CW'(2) && b2 == "ID") dec_cmd = sacd_pkg::CMD_ID;
    else if (blen == CW'(5) && b2 == "ID" && dg[2] && dg[3] && dg[4]
             && {6'b0, v3[9:0]} <= {6'b0, sacd_pkg::ID_SET_MAX} && v3 < 14'd1000) begin
      dec_cmd = sacd_pkg::CMD_ADDR_SET; dec_arg = v3;
    end
    else if (blen == CW'(3) && b3 == "ULK") dec_cmd = sacd_pkg::CMD_ULK;
    else if (blen == CW'(3) && b3 == "ULM") dec_cmd = sacd_pkg::CMD_ULM;
    else if (blen == CW'(3) && b3 == "ULR") dec_cmd = sacd_pkg::CMD_ULR;
    else if (blen == CW'(3) && b3 == "MOD") dec_cmd = sacd_pkg::CMD_MOD;
    else if ((blen == CW'(4) || blen == CW'(5)) && b3 == "MOD" && dg[3]
             && (blen == CW'(4) || dg[4]) && mv < 14'd16
             && mv[3:0] <= mode_highest && mode_supported_mask[mv[3:0]]) begin
      dec_cmd = sacd_pkg::CMD_MOD_SET; dec_arg = mv;
    end
    else if (blen == CW'(3) && b3 == "RAD") dec_cmd = sacd_pkg::CMD_RAD;
    else if (blen == CW'(3) && b3 == "DPT") dec_cmd = sacd_pkg::CMD_DPT;
    else if (blen == CW'(3) && b3 == "DCT") dec_cmd = sacd_pkg::CMD_DCT;
    else if (blen == CW'(3) && b3 == "DST") dec_cmd = sacd_pkg::CMD_DST;
    else if (blen == CW'(2) && b2 == "BD") dec_cmd = sacd_pkg::CMD_BD;
    else if (blen == CW'(3) && b2 == "BD" && dg[2] && v1a >= 14'd1 && v1a <= 14'd8) begin
      dec_cmd = sacd_pkg::CMD_BD_SET; dec_arg = v1a;
    end
    else if (blen == CW'(2) && b2 == "SP") dec_cmd = sacd_pkg::CMD_SP;
    else if (blen == CW'(5) && b2 == "SP" && dg[2] && dg[3] && dg[4]
             && v3 <= {4'b0, torque_limit_max}) begin
      dec_cmd = sacd_pkg::CMD_SP_SET; dec_arg = v3;
    end
    else if (blen == CW'(3) && b3 == "AMI") dec_cmd = sacd_pkg::CMD_AMI;
    else if (blen == CW'(3) && b3 == "AMX") dec_cmd = sacd_pkg::CMD_AMX;
    else if (blen == CW'(3) && b3 == "SMI") dec_cmd = sacd_pkg::CMD_SMI;
    else if (blen == CW'(3) && b3 == "SMX") dec_cmd = sacd_pkg::CMD_SMX;
    else if (blen == CW'(3) && b3 == "SCK") dec_cmd = sacd_pkg::CMD_SCK;
    else if (blen == CW'(3) && b3 == "SCZ") dec_cmd = sacd_pkg::CMD_SCZ;
    else if (blen == CW'(3) && b3 == "RIV") dec_cmd = sacd_pkg::CMD_RIV;
    else if (blen == CW'(3) && b3 == "CSD") dec_cmd = sacd_pkg::CMD_CSD;
    else if (blen == CW'(3) && b3 == "CSM") dec_cmd = sacd_pkg::CMD_CSM;
    else if (blen == CW'(4) && b3 == "CSM" && dg[3] && v1b >= {10'b0, boot_lowest}
             && v1b <= {10'b0, boot_highest}) begin
      dec_cmd = sacd_pkg::CMD_CSM_SET; dec_arg = v1b;
    end
    else if (blen == CW'(4) && {b3, body[3]} == "CLE0") dec_cmd = sacd_pkg::CMD_CLE0;
    else if (blen == CW'(3) && b3 == "CLE") dec_cmd = sacd_pkg::CMD_CLE;
    else if (blen == CW'(3) && b3 == "RTV") dec_cmd = sacd_pkg::CMD_RTV;
    else dec_ok = 1'b0;
  end

endmodule

### sv/sacd_checker.sv
// ----------------------------------------------------------------------------
// sacd_checker
// Port-level checks for the servo ASCII command deframer.
// ----------------------------------------------------------------------------
module sacd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  command,
  input logic [13:0] target_pulse,
  input logic [3:0]  turns
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(command))
    else $error("result dropped while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> command <= sacd_pkg::CMD_RIV)
    else $error("command out of range");

  a_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && command != sacd_pkg::CMD_GOTO && command != sacd_pkg::CMD_GOTO_TURNS
    |-> target_pulse == 14'd0 && turns == 4'd0)
    else $error("pulse on non-move command");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("busy after reset");

endmodule

bind servo_ascii_command_deframer sacd_checker u_sacd_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .command(command),
  .target_pulse(target_pulse), .turns(turns)
);
